// ----- hw/rtl/nls_pkg.sv -----
// Shared types, constants and character-class functions for the numeric literal scanner.
package nls_pkg;

  // Digit limits for the two literal forms.
  localparam int DecDigits = 5;
  localparam int HexDigits = 4;

  // Largest value that fits the 16-bit result.
  localparam logic [16:0] ValueMax = 17'h0ffff;

  // Character codes the scanner looks for.
  localparam logic [7:0] ChZero    = 8'h30;  // '0'
  localparam logic [7:0] ChNine    = 8'h39;  // '9'
  localparam logic [7:0] ChLowA    = 8'h61;  // 'a'
  localparam logic [7:0] ChLowF    = 8'h66;  // 'f'
  localparam logic [7:0] ChLowZ    = 8'h7a;  // 'z'
  localparam logic [7:0] ChUpA     = 8'h41;  // 'A'
  localparam logic [7:0] ChUpF     = 8'h46;  // 'F'
  localparam logic [7:0] ChUpZ     = 8'h5a;  // 'Z'
  localparam logic [7:0] ChUscore  = 8'h5f;  // '_'
  localparam logic [7:0] ChLowX    = 8'h78;  // 'x'
  localparam logic [7:0] ChNewLine = 8'h0a;
  localparam logic [7:0] ChReturn  = 8'h0d;
  // Offsets that map 'a'..'f' and 'A'..'F' onto 10..15.
  localparam logic [7:0] LowHexBase = 8'h57;
  localparam logic [7:0] UpHexBase  = 8'h37;

  // Scan phase of the literal being built.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ZERO  = 3'd1,
    PH_XSEEN = 3'd2,
    PH_DEC   = 3'd3,
    PH_HEX   = 3'd4
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTHING  = 3'd1,
    ST_NOTNUM   = 3'd2,
    ST_EOL      = 3'd3,
    ST_EOS      = 3'd4,
    ST_BADLIT   = 3'd5,
    ST_NOHEX    = 3'd6,
    ST_OVERFLOW = 3'd7
  } status_e;

  // One input request as held in the input register.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } item_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [15:0] value;
    status_e     status;
    logic        char_consumed;
  } result_t;

  function automatic logic is_dec(logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= ChLowA) && (c <= ChLowZ)) || ((c >= ChUpA) && (c <= ChUpZ)) ||
           (c == ChUscore);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dec(c) || ((c >= ChLowA) && (c <= ChLowF)) || ((c >= ChUpA) && (c <= ChUpF));
  endfunction

  function automatic logic is_eol(logic [7:0] c);
    return (c == ChNewLine) || (c == ChReturn);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] diff;
    if (is_dec(c)) begin
      diff = c - ChZero;
    end else if ((c >= ChLowA) && (c <= ChLowF)) begin
      diff = c - LowHexBase;
    end else begin
      diff = c - UpHexBase;
    end
    return diff[3:0];
  endfunction

endpackage

// ----- hw/rtl/nls_req_if.sv -----
// Request channel carrying one character byte or an end-of-stream mark.
interface nls_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_stream;

  modport source (output valid, output char_code, output end_of_stream, input ready);
  modport sink (input valid, input char_code, input end_of_stream, output ready);
endinterface

// ----- hw/rtl/nls_res_if.sv -----
// Result channel carrying the parsed value, its status and the consumed flag.
interface nls_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic [2:0]  status;
  logic        char_consumed;

  modport source (output valid, output value, output status, output char_consumed,
                  input ready);
  modport sink (input valid, input value, input status, input char_consumed,
                output ready);
endinterface

// ----- hw/rtl/numeric_literal_scanner_u16.sv -----
// Top level of the numeric literal scanner: input register, scan step and output register.
//
// Usage: the source sends one character byte per request on req_i, or a request with
// end_of_stream set when the text ends. The scanner builds one unsigned 16-bit literal:
// up to five decimal digits, or 0x and up to four hex digits. A request that ends,
// breaks or completes a literal, or finds none at idle, gives one result on res_o with the
// value, a status code and whether that request's character belonged to the literal; other
// requests give no result. Characters not consumed must be sent again by the source.
// Order: a request is held in the input register while the scan step runs, and its
// result is then loaded into the output register, which drives res_o.
// Throughput: one request per cycle while res_o is not stalled; the scan step is one
// multiply-by-ten add and a compare, and its state is ready for the next character.
// Stalls: while res_o is stalled the input register still drains requests that give
// no result; a request that gives one waits in the input register, and req_i.ready
// drops only then.
// Reset: rst_ni empties both registers and returns the scanner to idle with an empty
// accumulator.
module numeric_literal_scanner_u16 (
  input  logic      clk_i,
  input  logic      rst_ni,
  nls_req_if.sink   req_i,
  nls_res_if.source res_o
);

  logic             s1_valid;
  nls_pkg::item_t   s1_item;
  logic             emit;
  nls_pkg::result_t result;
  logic             out_free;
  logic             advance;
  logic             load;

  // The held request moves on unless it has a result and the output is full.
  assign advance = s1_valid && (!emit || out_free);
  assign load    = advance && emit;

  nls_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  nls_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .item_i    (s1_item),
    .advance_i (advance),
    .emit_o    (emit),
    .result_o  (result)
  );

  nls_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .result_i (result),
    .free_o   (out_free),
    .res_o    (res_o)
  );

  // A held request that cannot move stays unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_item)))
    else $error("held request lost or changed while stalled");

  // A stalled request only waits behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !advance) |-> (res_o.valid && !res_o.ready && emit))
    else $error("request stalled without a full output");

  // A value other than zero only comes with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.value != 16'd0)) |-> (res_o.status == nls_pkg::ST_OK))
    else $error("nonzero value with an error status");

  // Nothing and not-numeric results never consume the character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && ((res_o.status == nls_pkg::ST_NOTHING) ||
                     (res_o.status == nls_pkg::ST_NOTNUM))) |-> !res_o.char_consumed)
    else $error("character consumed without a literal");

  // A result is loaded only into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("result loaded over a pending result");

endmodule

// ----- hw/rtl/nls_in_reg.sv -----
// Input register holding one accepted request until the scan logic takes it.
module nls_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  nls_req_if.sink       req_i,
  input  logic          advance_i,
  output logic          valid_o,
  output nls_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  nls_pkg::item_t item_q;
  logic           accept;

  // A request enters when the register is empty or is being emptied.
  assign req_i.ready = !valid_q || advance_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.char_code     <= req_i.char_code;
      item_q.end_of_stream <= req_i.end_of_stream;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hw/rtl/nls_core.sv -----
// Scan state and the single-step logic that folds one character into the literal.
module nls_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  nls_pkg::item_t    item_i,
  input  logic              advance_i,
  output logic              emit_o,
  output nls_pkg::result_t  result_o
);

  nls_pkg::phase_e  phase_q, phase_d;
  logic [16:0]      acc_q, acc_d;
  logic [2:0]       cnt_q, cnt_d;

  logic [7:0]       c;
  logic             eos;
  logic [7:0]       dec_diff;
  logic [3:0]       dval;
  logic [3:0]       hval;
  logic [19:0]      acc_mul;
  logic [16:0]      acc_dec;
  logic [16:0]      acc_hex;
  logic [2:0]       cnt_inc;

  logic             emit;
  logic             emit_num;
  logic             used;
  nls_pkg::status_e emit_st;
  logic [16:0]      acc_nx;

  assign c   = item_i.char_code;
  assign eos = item_i.end_of_stream;

  // Digit values and the two accumulate forms (times ten, shift by four).
  assign dec_diff = c - nls_pkg::ChZero;
  assign dval     = dec_diff[3:0];
  assign hval     = nls_pkg::hex_val(c);
  assign acc_mul  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {16'd0, dval};
  assign acc_dec  = acc_mul[16:0];
  assign acc_hex  = {acc_q[12:0], hval};
  assign cnt_inc  = cnt_q + 3'd1;

  // Next state and the decision to give a result.
  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    emit     = 1'b0;
    emit_num = 1'b0;
    used     = 1'b0;
    emit_st  = nls_pkg::ST_OK;
    acc_nx   = acc_q;

    case (phase_q)
      nls_pkg::PH_ZERO: begin
        if (eos) begin
          emit = 1'b1;
        end else if (c == nls_pkg::ChLowX) begin
          phase_d = nls_pkg::PH_XSEEN;
        end else if (nls_pkg::is_letter(c)) begin
          emit    = 1'b1;
          emit_st = nls_pkg::ST_BADLIT;
          used    = 1'b1;
        end else begin
          emit = 1'b1;
          used = 1'b1;
        end
      end

      nls_pkg::PH_XSEEN: begin
        if (eos) begin
          emit    = 1'b1;
          emit_st = nls_pkg::ST_EOS;
        end else if (nls_pkg::is_eol(c)) begin
          emit    = 1'b1;
          emit_st = nls_pkg::ST_EOL;
          used    = 1'b1;
        end else if (!nls_pkg::is_hex(c)) begin
          emit    = 1'b1;
          emit_st = nls_pkg::ST_NOHEX;
          used    = 1'b1;
        end else begin
          acc_nx = {13'd0, hval};
          cnt_d  = 3'd1;
          if (3'd1 >= 3'(nls_pkg::HexDigits)) begin
            emit     = 1'b1;
            emit_num = 1'b1;
            used     = 1'b1;
          end else begin
            phase_d = nls_pkg::PH_HEX;
            acc_d   = acc_nx;
          end
        end
      end

      nls_pkg::PH_HEX: begin
        if (eos) begin
          emit     = 1'b1;
          emit_num = 1'b1;
        end else if (!nls_pkg::is_hex(c)) begin
          emit     = 1'b1;
          emit_num = 1'b1;
          used     = 1'b1;
        end else begin
          acc_nx = acc_hex;
          cnt_d  = cnt_inc;
          acc_d  = acc_hex;
          if (cnt_inc >= 3'(nls_pkg::HexDigits)) begin
            emit     = 1'b1;
            emit_num = 1'b1;
            used     = 1'b1;
          end
        end
      end

      nls_pkg::PH_DEC: begin
        if (eos) begin
          emit     = 1'b1;
          emit_num = 1'b1;
        end else if (!nls_pkg::is_dec(c)) begin
          emit     = 1'b1;
          emit_num = 1'b1;
          used     = 1'b1;
        end else begin
          acc_nx = acc_dec;
          cnt_d  = cnt_inc;
          acc_d  = acc_dec;
          if (cnt_inc >= 3'(nls_pkg::DecDigits)) begin
            emit     = 1'b1;
            emit_num = 1'b1;
            used     = 1'b1;
          end
        end
      end

      default: begin
        if (eos) begin
          emit    = 1'b1;
          emit_st = nls_pkg::ST_NOTHING;
        end else if (!nls_pkg::is_dec(c)) begin
          emit    = 1'b1;
          emit_st = nls_pkg::ST_NOTNUM;
        end else if (c == nls_pkg::ChZero) begin
          phase_d = nls_pkg::PH_ZERO;
          acc_d   = 17'd0;
          cnt_d   = 3'd1;
        end else begin
          acc_nx = {13'd0, dval};
          cnt_d  = 3'd1;
          if (3'd1 >= 3'(nls_pkg::DecDigits)) begin
            emit     = 1'b1;
            emit_num = 1'b1;
            used     = 1'b1;
          end else begin
            phase_d = nls_pkg::PH_DEC;
            acc_d   = acc_nx;
          end
        end
      end
    endcase

    // Any result returns the scanner to idle.
    if (emit) begin
      phase_d = nls_pkg::PH_IDLE;
      acc_d   = 17'd0;
      cnt_d   = 3'd0;
    end
  end

  // Result fields; a number above the 16-bit range is flagged, not saturated.
  always_comb begin
    result_o.char_consumed = used;
    result_o.value         = 16'd0;
    result_o.status        = emit_st;
    if (emit_num) begin
      if (acc_nx > nls_pkg::ValueMax) begin
        result_o.status = nls_pkg::ST_OVERFLOW;
      end else begin
        result_o.status = nls_pkg::ST_OK;
        result_o.value  = acc_nx[15:0];
      end
    end
  end

  assign emit_o = valid_i && emit;

  // The state moves only when the held character is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nls_pkg::PH_IDLE;
      acc_q   <= 17'd0;
      cnt_q   <= 3'd0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/nls_out_reg.sv -----
// Output register presenting one result until the receiver takes it.
module nls_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  nls_pkg::result_t result_i,
  output logic             free_o,
  nls_res_if.source        res_o
);

  logic             valid_q, valid_d;
  nls_pkg::result_t result_q;

  // The register is free when empty or when its result leaves this cycle.
  assign free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.value         = result_q.value;
  assign res_o.status        = result_q.status;
  assign res_o.char_consumed = result_q.char_consumed;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the numeric literal scanner, with a character-stream predictor.
module tb;
  import nls_pkg::*;

  logic clk_i;
  logic rst_ni;

  nls_req_if req_if ();
  nls_res_if res_if ();

  numeric_literal_scanner_u16 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Characters waiting to be sent, and literal results waiting to be seen.
  item_t   text_q[$];
  result_t literal_q[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int pushed_cnt      = 0;
  int accepted_cnt    = 0;
  int checked_cnt     = 0;
  int mismatch_cnt    = 0;
  int status_seen[8];

  // Predictor state: the literal being built.
  phase_e      scan_ph  = PH_IDLE;
  logic [16:0] scan_acc = '0;
  logic [2:0]  scan_cnt = '0;

  // Character classes.
  function automatic logic ch_is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic ch_is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic ch_is_hex(logic [7:0] c);
    return ch_is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic ch_is_eol(logic [7:0] c);
    return c == 8'h0a || c == 8'h0d;
  endfunction

  function automatic logic [3:0] ch_weight(logic [7:0] c);
    logic [7:0] w;
    if (ch_is_digit(c)) begin
      w = c - "0";
    end else if (c >= "a" && c <= "f") begin
      w = c - "a" + 8'd10;
    end else begin
      w = c - "A" + 8'd10;
    end
    return w[3:0];
  endfunction

  // Ends the literal with a result and returns the scanner to idle.
  function automatic result_t close_literal(logic [15:0] val, status_e st, logic used);
    result_t r;
    r.value         = (st == ST_OK) ? val : 16'd0;
    r.status        = st;
    r.char_consumed = used;
    scan_ph  = PH_IDLE;
    scan_acc = '0;
    scan_cnt = '0;
    return r;
  endfunction

  function automatic result_t close_number(logic used);
    if (scan_acc > ValueMax) begin
      return close_literal(16'd0, ST_OVERFLOW, used);
    end
    return close_literal(scan_acc[15:0], ST_OK, used);
  endfunction

  // Advances the predictor by one character and says whether a result follows.
  function automatic void lex_step(input logic [7:0] c, input logic eos,
                                   output logic fired, output result_t r);
    fired = 1'b1;
    r     = '0;
    case (scan_ph)
      PH_ZERO: begin
        if (eos) begin
          r = close_literal(16'd0, ST_OK, 1'b0);
        end else if (c == "x") begin
          scan_ph = PH_XSEEN;
          fired   = 1'b0;
        end else if (ch_is_letter(c)) begin
          r = close_literal(16'd0, ST_BADLIT, 1'b1);
        end else begin
          r = close_literal(16'd0, ST_OK, 1'b1);
        end
      end
      PH_XSEEN: begin
        if (eos) begin
          r = close_literal(16'd0, ST_EOS, 1'b0);
        end else if (ch_is_eol(c)) begin
          r = close_literal(16'd0, ST_EOL, 1'b1);
        end else if (!ch_is_hex(c)) begin
          r = close_literal(16'd0, ST_NOHEX, 1'b1);
        end else begin
          scan_acc = 17'(ch_weight(c));
          scan_cnt = 3'd1;
          if (scan_cnt >= HexDigits) begin
            r = close_number(1'b1);
          end else begin
            scan_ph = PH_HEX;
            fired   = 1'b0;
          end
        end
      end
      PH_HEX: begin
        if (eos) begin
          r = close_number(1'b0);
        end else if (!ch_is_hex(c)) begin
          r = close_number(1'b1);
        end else begin
          scan_acc = (scan_acc << 4) + 17'(ch_weight(c));
          scan_cnt = scan_cnt + 3'd1;
          if (scan_cnt >= HexDigits) begin
            r = close_number(1'b1);
          end else begin
            fired = 1'b0;
          end
        end
      end
      PH_DEC: begin
        if (eos) begin
          r = close_number(1'b0);
        end else if (!ch_is_digit(c)) begin
          r = close_number(1'b1);
        end else begin
          scan_acc = 17'(scan_acc * 10 + ch_weight(c));
          scan_cnt = scan_cnt + 3'd1;
          if (scan_cnt >= DecDigits) begin
            r = close_number(1'b1);
          end else begin
            fired = 1'b0;
          end
        end
      end
      default: begin
        // Idle, and any phase code that is never used.
        if (eos) begin
          r = close_literal(16'd0, ST_NOTHING, 1'b0);
        end else if (!ch_is_digit(c)) begin
          r = close_literal(16'd0, ST_NOTNUM, 1'b0);
        end else if (c == "0") begin
          scan_ph  = PH_ZERO;
          scan_acc = '0;
          scan_cnt = 3'd1;
          fired    = 1'b0;
        end else begin
          scan_acc = 17'(ch_weight(c));
          scan_cnt = 3'd1;
          if (scan_cnt >= DecDigits) begin
            r = close_number(1'b1);
          end else begin
            scan_ph = PH_DEC;
            fired   = 1'b0;
          end
        end
      end
    endcase
  endfunction

  // Stimulus helpers.
  task automatic queue_char(logic [7:0] c);
    item_t it;
    it.char_code     = c;
    it.end_of_stream = 1'b0;
    text_q.push_back(it);
    pushed_cnt++;
  endtask

  task automatic queue_eos();
    item_t it;
    // The character byte is ignored at the end of the stream, so it is left random.
    it.char_code     = 8'($urandom_range(255));
    it.end_of_stream = 1'b1;
    text_q.push_back(it);
    pushed_cnt++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      queue_char(s[i]);
    end
  endtask

  task automatic queue_terminator();
    case ($urandom_range(5))
      0: queue_eos();
      1: queue_char(8'h0a);
      2: queue_char(8'h0d);
      3: queue_char(" ");
      4: queue_char(",");
      default: queue_char(8'($urandom_range(255)));
    endcase
  endtask

  // One literal with random content, a broken one, or a little noise.
  task automatic queue_random_literal();
    string hex_set;
    int    kind;
    int    n;
    hex_set = "0123456789abcdefABCDEF";
    kind    = $urandom_range(99);
    if (kind < 40) begin
      n = $urandom_range(1, 5);
      queue_char(8'("1" + $urandom_range(8)));
      for (int i = 1; i < n; i++) begin
        queue_char(8'("0" + $urandom_range(9)));
      end
      if (n < DecDigits) begin
        queue_terminator();
      end
    end else if (kind < 70) begin
      // One in ten hex literals has no digits at all.
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
      queue_text("0x");
      for (int i = 0; i < n; i++) begin
        queue_char(hex_set[$urandom_range(21)]);
      end
      if (n < HexDigits) begin
        queue_terminator();
      end
    end else if (kind < 80) begin
      queue_char("0");
      case ($urandom_range(3))
        0: queue_char(($urandom_range(1) == 0) ? 8'("a" + $urandom_range(25)) : "Q");
        1: queue_terminator();
        2: queue_char(8'("0" + $urandom_range(9)));
        default: begin
          queue_char("x");
          queue_terminator();
        end
      endcase
    end else begin
      if ($urandom_range(9) == 0) begin
        queue_eos();
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          queue_char(8'($urandom_range(255)));
        end
      end
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: takes the next character from the queue when the channel is free.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    item_t next_item;
    if (!rst_ni) begin
      req_if.valid         <= 1'b0;
      req_if.char_code     <= '0;
      req_if.end_of_stream <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (text_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_item = text_q.pop_front();
        req_if.valid         <= 1'b1;
        req_if.char_code     <= next_item.char_code;
        req_if.end_of_stream <= next_item.end_of_stream;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk_i) begin : observe
    logic    fired;
    result_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        accepted_cnt++;
        lex_step(req_if.char_code, req_if.end_of_stream, fired, want);
        if (fired) begin
          literal_q.push_back(want);
        end
      end
      if (res_if.valid && res_if.ready) begin
        if (literal_q.size() == 0) begin
          $error("unexpected result: value %0d, status %0d, char_consumed %0d",
                 res_if.value, res_if.status, res_if.char_consumed);
          mismatch_cnt++;
        end else begin
          want = literal_q.pop_front();
          checked_cnt++;
          status_seen[want.status]++;
          if (res_if.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, res_if.value);
            mismatch_cnt++;
          end
          if (res_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_if.status);
            mismatch_cnt++;
          end
          if (res_if.char_consumed !== want.char_consumed) begin
            $error("char_consumed: expected %0d, got %0d", want.char_consumed,
                   res_if.char_consumed);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Main sequence: reset, three back-pressure phases, drain and verdict.
  initial begin : run
    int kinds;
    req_if.valid         = 1'b0;
    req_if.char_code     = '0;
    req_if.end_of_stream = 1'b0;
    res_if.ready         = 1'b0;
    rst_ni               = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 35;
          recv_stall_pct  = 57;
        end
        1: begin
          sender_idle_pct = 57;
          recv_stall_pct  = 35;
        end
        default: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
      endcase
      if (ph == 0) begin
        // Stream end and non-digits at idle, with the extreme byte values.
        queue_eos();
        queue_char(8'h00);
        queue_char(8'hff);
        // Lone zero closed by the stream end, and followed by a letter.
        queue_char("0");
        queue_eos();
        queue_text("0q");
        // Hex prefix closed by end of line, by stream end and by a non-hex character.
        queue_text("0x\r");
        queue_text("0x");
        queue_eos();
        queue_text("0xg");
        // Decimal overflow reached at the digit limit, then a short number.
        queue_text("65536");
        queue_text("7,");
      end
      while (pushed_cnt < (ph + 1) * 367) begin
        queue_random_literal();
      end
      // Wait until every character of this phase is accepted and every literal checked.
      while (accepted_cnt != pushed_cnt || literal_q.size() != 0) begin
        @(posedge clk_i);
      end
    end

    repeat (6) @(posedge clk_i);
    kinds = 0;
    foreach (status_seen[i]) begin
      if (status_seen[i] > 0) kinds++;
    end
    $display("Scanned %0d characters under three back-pressure profiles.", accepted_cnt);
    $display("Checked %0d literal results covering %0d of 8 status codes.", checked_cnt,
             kinds);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
